// ===== rtl/sptt_pkg.sv =====
// Shared types and constants for the sparse polynomial term table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sptt_pkg;
  localparam int CoefW  = 32;
  localparam int ExponW = 16;
  localparam int StatW  = 3;
  localparam int OpW    = 4;

  localparam logic [OpW-1:0] OP_ATTACH_A = 4'd0;
  localparam logic [OpW-1:0] OP_ATTACH_B = 4'd1;
  localparam logic [OpW-1:0] OP_ADD      = 4'd2;
  localparam logic [OpW-1:0] OP_SCALE    = 4'd3;
  localparam logic [OpW-1:0] OP_REMOVE   = 4'd4;
  localparam logic [OpW-1:0] OP_MULT     = 4'd5;
  localparam logic [OpW-1:0] OP_LEAD     = 4'd6;
  localparam logic [OpW-1:0] OP_CLEAR_A  = 4'd7;
  localparam logic [OpW-1:0] OP_CLEAR_B  = 4'd8;
  localparam logic [OpW-1:0] OP_READ     = 4'd9;

  localparam logic [StatW-1:0] ST_OK    = 3'd0;
  localparam logic [StatW-1:0] ST_FULL  = 3'd1;
  localparam logic [StatW-1:0] ST_NF    = 3'd2;
  localparam logic [StatW-1:0] ST_EMPTY = 3'd3;
  localparam logic [StatW-1:0] ST_EOVF  = 3'd4;

  // Saturate a 64-bit signed value to 32 bits.
  function automatic logic signed [CoefW-1:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    begin
      hi = 64'sh0000_0000_7FFF_FFFF;
      lo = -64'sh0000_0000_8000_0000;
      if (v > hi) sat32 = 32'sh7FFF_FFFF;
      else if (v < lo) sat32 = 32'sh8000_0000;
      else sat32 = v[CoefW-1:0];
    end
  endfunction
endpackage
`default_nettype wire

// ===== rtl/sptt_mem.sv =====
// Term memory: one coefficient and exponent pair per entry.
// Uses sptt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sptt_mem
  import sptt_pkg::*;
#(
  parameter int Depth = 64,
  parameter int AW = 6
) (
  input  wire              clk,
  input  wire              we,
  input  wire [AW-1:0]     waddr,
  input  wire [CoefW-1:0]  wcoef,
  input  wire [ExponW-1:0] wexpon,
  input  wire [AW-1:0]     raddr,
  output logic [CoefW-1:0]  rcoef,
  output logic [ExponW-1:0] rexpon
);
  logic [CoefW+ExponW-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= {wcoef, wexpon};
    {rcoef, rexpon} <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/sparse_polynomial_term_table_top.sv =====
// Top level of the sparse polynomial term table: sequencer plus three term memories.
// Uses sptt_pkg and sptt_mem.
`timescale 1ns / 1ps
`default_nettype none
// Holds polynomials A and B, each up to DEPTH terms sorted by descending
// exponent, in memories with a registered read, plus a scratch table for
// products. One word is taken at a time; a sequencer walks the memories one
// entry per step, each step being a read then a modify/write. Attach
// searches then shifts, remove the same, scale walks every term, add B into
// A one attach per B term, multiply one merge per term pair plus a copy of
// the product table, read one result per term. Words out go through an
// output register, so the next result is prepared while the previous one
// waits. Coefficients saturate to 32-bit signed.
module sparse_polynomial_term_table_top
  import sptt_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire [OpW-1:0]           operation,
  input  wire signed [CoefW-1:0]  term_coef,
  input  wire [ExponW-1:0]        term_expon,
  input  wire signed [15:0]       scale_factor,
  output logic                    out_valid,
  input  wire                     out_ready,
  output logic signed [CoefW-1:0] out_coef,
  output logic [ExponW-1:0]       out_expon,
  output logic [6:0]              term_count,
  output logic [StatW-1:0]        status,
  output logic                    last
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_SRD    = 13'b0000000000010, // search: read issued
    S_SCHK   = 13'b0000000000100, // search: compare
    S_SHRD   = 13'b0000000001000, // shift: read neighbor entry
    S_SHWR   = 13'b0000000010000, // shift: write entry k
    S_INS    = 13'b0000000100000, // insert at position
    S_SRC    = 13'b0000001000000, // fetch source term (B, A-pair)
    S_SRCW   = 13'b0000010000000, // source data ready
    S_SCL    = 13'b0000100000000, // scale write
    S_MUL    = 13'b0001000000000, // product register stage
    S_CPY    = 13'b0010000000000, // copy prod into A
    S_EMIT   = 13'b0100000000000, // push one result
    S_RDWAIT = 13'b1000000000000  // read data latency
  } state_t;

  state_t state;
  logic [OpW-1:0] op;
  logic signed [CoefW-1:0] mcoef;   // term being merged
  logic [ExponW-1:0] mexp;
  logic signed [15:0] fac;
  logic [1:0] tsel;                 // target table: 0 A, 1 B, 2 prod
  logic [CW-1:0] a_count, b_count, p_count;
  logic [CW-1:0] idx, k, i, j;
  logic signed [63:0] prod;
  logic [StatW-1:0] st;

  // memory ports
  logic a_we, b_we, p_we;
  logic [AW-1:0] a_wa, b_wa, p_wa, a_ra, b_ra, p_ra;
  logic [CoefW-1:0] wc;
  logic signed [CoefW-1:0] a_rc, b_rc, p_rc;
  logic [ExponW-1:0] we_x, a_rx, b_rx, p_rx;

  sptt_mem #(.Depth(DEPTH), .AW(AW)) u_a (.clk, .we(a_we), .waddr(a_wa), .wcoef(wc),
    .wexpon(we_x), .raddr(a_ra), .rcoef(a_rc), .rexpon(a_rx));
  sptt_mem #(.Depth(DEPTH), .AW(AW)) u_b (.clk, .we(b_we), .waddr(b_wa), .wcoef(wc),
    .wexpon(we_x), .raddr(b_ra), .rcoef(b_rc), .rexpon(b_rx));
  sptt_mem #(.Depth(DEPTH), .AW(AW)) u_p (.clk, .we(p_we), .waddr(p_wa), .wcoef(wc),
    .wexpon(we_x), .raddr(p_ra), .rcoef(p_rc), .rexpon(p_rx));

  // output register; a waiting word only holds the sequencer in S_EMIT
  logic ob_full;
  assign out_valid = ob_full;
  assign in_ready = (state == S_IDLE);

  // target table view
  logic [CW-1:0] t_count;
  logic signed [CoefW-1:0] t_rc;
  logic [ExponW-1:0] t_rx;
  always_comb begin
    unique case (tsel)
      2'd1:    begin t_count = b_count; t_rc = b_rc; t_rx = b_rx; end
      2'd2:    begin t_count = p_count; t_rc = p_rc; t_rx = p_rx; end
      default: begin t_count = a_count; t_rc = a_rc; t_rx = a_rx; end
    endcase
  end

  // combinational control of memory ports
  logic t_we;
  logic [AW-1:0] t_wa, t_ra;
  logic [AW-1:0] km1, kp1;
  logic signed [CoefW-1:0] merged;
  logic [16:0] esum;
  logic signed [63:0] rnd;
  logic signed [CoefW-1:0] qprod;
  assign km1 = AW'(k - CW'(1));
  assign kp1 = AW'(k + CW'(1));
  assign merged = sat32(64'(t_rc) + 64'(mcoef));
  assign esum = {1'b0, a_rx} + {1'b0, b_rx};
  assign rnd = prod + 64'sd32768;
  assign qprod = sat32(rnd >>> 16); // floor division matches the rounding rule

  always_comb begin
    t_we = 1'b0; t_wa = AW'(idx); t_ra = AW'(idx);
    wc = mcoef; we_x = mexp;
    a_ra = AW'(idx); b_ra = AW'(idx); p_ra = AW'(idx);
    a_we = 1'b0; b_we = 1'b0; p_we = 1'b0;
    a_wa = AW'(idx); b_wa = AW'(idx); p_wa = AW'(idx);
    unique case (state)
      S_SCHK: begin
        if (op != OP_REMOVE && idx < t_count && t_rx == mexp) begin
          t_we = 1'b1; wc = merged;
        end
      end
      // remove pulls entry k+1 down, insert pushes entry k-1 up
      S_SHRD: t_ra = (op == OP_REMOVE) ? kp1 : km1;
      S_SHWR: begin t_we = 1'b1; t_wa = AW'(k); wc = t_rc; we_x = t_rx; end
      S_INS:  t_we = 1'b1;
      S_SCL: begin
        t_we = 1'b1; wc = sat32(64'(a_rc) * 64'(fac)); we_x = a_rx;
      end
      S_SRC: begin a_ra = AW'(i); b_ra = AW'(j); end
      S_CPY: begin
        // first cycle only primes the read; nothing past the product count
        a_we = (op == OP_MULT) && (k < p_count) && (idx != k);
        a_wa = AW'(k); wc = p_rc; we_x = p_rx;
      end
      default: ;
    endcase
    if (state == S_CPY || state == S_IDLE) p_ra = AW'(idx);
    else if (state != S_SRC) begin
      a_ra = t_ra; b_ra = t_ra; p_ra = t_ra;
    end
    if (state == S_SHWR || state == S_SCHK || state == S_INS || state == S_SCL) begin
      unique case (tsel)
        2'd1:    begin b_we = t_we; b_wa = t_wa; end
        2'd2:    begin p_we = t_we; p_wa = t_wa; end
        default: begin a_we = t_we; a_wa = t_wa; end
      endcase
    end
  end

  // result staging
  logic signed [CoefW-1:0] e_coef;
  logic [ExponW-1:0] e_exp;
  logic e_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; ob_full <= 1'b0;
      a_count <= '0; b_count <= '0; p_count <= '0;
    end else begin
      if (ob_full && out_ready && state != S_EMIT) ob_full <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid && in_ready) begin
          op <= operation; mcoef <= term_coef; mexp <= term_expon;
          fac <= scale_factor; st <= ST_OK; idx <= '0; i <= '0; j <= '0;
          e_coef <= '0; e_exp <= '0; e_last <= 1'b1;
          unique case (operation)
            OP_ATTACH_A, OP_REMOVE: begin tsel <= 2'd0; state <= S_SRD; end
            OP_ATTACH_B: begin tsel <= 2'd1; state <= S_SRD; end
            OP_ADD: begin
              tsel <= 2'd0;
              state <= (b_count == '0) ? S_EMIT : S_SRC;
            end
            OP_SCALE: begin tsel <= 2'd0; state <= S_RDWAIT; end
            OP_MULT: begin
              tsel <= 2'd2; p_count <= '0;
              state <= (a_count == '0 || b_count == '0) ? S_CPY : S_SRC;
              k <= '0;
            end
            OP_LEAD, OP_READ: begin
              tsel <= 2'd0;
              if (a_count == '0) begin st <= ST_EMPTY; state <= S_EMIT; end
              else state <= S_RDWAIT;
            end
            OP_CLEAR_A: begin a_count <= '0; state <= S_EMIT; end
            OP_CLEAR_B: begin b_count <= '0; state <= S_EMIT; end
            default: state <= S_EMIT;
          endcase
        end
        S_RDWAIT: begin
          // data for entry idx available next cycle
          if (op == OP_SCALE) begin
            if (idx >= a_count) state <= S_EMIT;
            else state <= S_SCL;
          end else state <= S_SRCW;
        end
        S_SCL: begin idx <= idx + CW'(1); state <= S_RDWAIT; end
        S_SRD: state <= S_SCHK;
        S_SCHK: begin
          if (op == OP_REMOVE) begin
            if (idx >= t_count) begin st <= ST_NF; state <= S_EMIT; end
            else if (t_rx == mexp) begin
              k <= idx; state <= S_SHRD; // shift down from idx
            end else begin idx <= idx + CW'(1); state <= S_SRD; end
          end else if (idx < t_count && t_rx == mexp) begin
            state <= S_SRC; // merged, continue
            j <= j + CW'(1);
          end else if (idx >= t_count || t_rx < mexp) begin
            if (t_count >= CW'(DEPTH)) begin
              if (op == OP_MULT) st <= ST_FULL;
              else st <= ST_FULL;
              state <= (op == OP_MULT) ? S_EMIT : S_SRC;
              j <= j + CW'(1);
            end else begin
              k <= t_count; state <= S_SHRD;
            end
          end else begin idx <= idx + CW'(1); state <= S_SRD; end
        end
        S_SHRD: begin
          if (op == OP_REMOVE) begin
            // moving entry k+1 into k: read k+1
            if (k + CW'(1) >= t_count) begin
              a_count <= a_count - CW'(1); state <= S_EMIT;
            end else state <= S_SHWR;
          end else if (k == idx) state <= S_INS;
          else state <= S_SHWR;
        end
        S_SHWR: begin
          if (op == OP_REMOVE) begin k <= k + CW'(1); state <= S_SHRD; end
          else begin k <= k - CW'(1); state <= S_SHRD; end
        end
        S_INS: begin
          unique case (tsel)
            2'd1:    b_count <= b_count + CW'(1);
            2'd2:    p_count <= p_count + CW'(1);
            default: a_count <= a_count + CW'(1);
          endcase
          j <= j + CW'(1);
          state <= S_SRC;
        end
        S_SRC: begin
          // continue the driving loop
          idx <= '0;
          if (op == OP_ATTACH_A || op == OP_ATTACH_B) state <= S_EMIT;
          else if (op == OP_ADD) begin
            if (j >= b_count) state <= S_EMIT;
            else state <= S_SRCW;
          end else begin
            if (j >= b_count) begin
              j <= '0; i <= i + CW'(1);
              if (i + CW'(1) >= a_count) begin k <= '0; state <= S_CPY; end
            end else state <= S_SRCW;
          end
        end
        S_SRCW: begin
          if (op == OP_LEAD || op == OP_READ) begin
            e_coef <= a_rc; e_exp <= a_rx;
            e_last <= (op == OP_LEAD) || (idx + CW'(1) >= a_count);
            state <= S_EMIT;
          end else if (op == OP_ADD) begin
            mcoef <= b_rc; mexp <= b_rx; state <= S_SRD;
          end else begin
            prod <= 64'(a_rc) * 64'(b_rc);
            if (esum[16]) begin
              st <= ST_EOVF; state <= S_EMIT;
            end else begin
              mexp <= esum[ExponW-1:0]; state <= S_MUL;
            end
          end
        end
        S_MUL: begin mcoef <= qprod; state <= S_SRD; end
        S_CPY: begin
          // idx leads k by one read
          if (op != OP_MULT || k >= p_count) begin
            if (op == OP_MULT) a_count <= p_count;
            state <= S_EMIT;
          end else if (idx == k) idx <= idx + CW'(1);
          else begin k <= k + CW'(1); idx <= idx + CW'(1); end
        end
        S_EMIT: if (!ob_full || out_ready) begin
          ob_full <= 1'b1;
          out_coef <= e_coef; out_expon <= e_exp; status <= st; last <= e_last;
          if (op == OP_READ && !e_last && st == ST_OK) begin
            idx <= idx + CW'(1); state <= S_RDWAIT;
          end else state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // term_count mirrors A's count at the moment the word is loaded
  always_ff @(posedge clk) begin
    if (state == S_EMIT && (!ob_full || out_ready)) term_count <= 7'(a_count);
  end
endmodule
`default_nettype wire

// ===== tb/sptt_checker.sv =====
// Scoreboard for the sparse polynomial term table: tracks the A, B and product tables, predicts
// every result word and compares it with what the block emits. Uses sptt_pkg.
`timescale 1ns / 1ps
module sptt_checker
  import sptt_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [OpW-1:0]           operation,
  input  logic signed [CoefW-1:0]  term_coef,
  input  logic [ExponW-1:0]        term_expon,
  input  logic signed [15:0]       scale_factor,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic signed [CoefW-1:0]  out_coef,
  input  logic [ExponW-1:0]        out_expon,
  input  logic [6:0]               term_count,
  input  logic [StatW-1:0]         status,
  input  logic                     last,
  output int                       fail_count,
  output int                       pending
);
  localparam int TermsMax = 64;
  localparam int TAB_A = 0;
  localparam int TAB_B = 1;
  localparam int TAB_P = 2;

  typedef struct packed {
    logic signed [CoefW-1:0] coef;
    logic [ExponW-1:0]       expon;
    logic [6:0]              cnt;
    logic [StatW-1:0]        st;
    logic                    lst;
  } term_word_t;

  logic signed [CoefW-1:0] poly_coef [3][TermsMax];
  logic [ExponW-1:0]       poly_expon[3][TermsMax];
  int                      poly_cnt  [3];
  term_word_t              expected_words[$];

  initial begin
    fail_count = 0;
    pending    = 0;
    for (int t = 0; t < 3; t++) poly_cnt[t] = 0;
  end

  function automatic logic signed [CoefW-1:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[CoefW-1:0];
  endfunction

  // Q16.16 product, round half up, saturated
  function automatic logic signed [CoefW-1:0] fixed_mul(logic signed [CoefW-1:0] x,
                                                        logic signed [CoefW-1:0] y);
    longint v;
    v = longint'(x) * longint'(y) + 64'sd32768;
    return clamp32(v >>> 16);
  endfunction

  // insert or accumulate into a descending-sorted table
  function automatic logic [StatW-1:0] merge_term(int t, logic signed [CoefW-1:0] c,
                                                  int unsigned ex);
    int i;
    i = 0;
    while (i < poly_cnt[t]) begin
      if (poly_expon[t][i] == ex) begin
        poly_coef[t][i] = clamp32(longint'(poly_coef[t][i]) + longint'(c));
        return ST_OK;
      end
      if (poly_expon[t][i] < ex) break;
      i++;
    end
    if (poly_cnt[t] >= TermsMax) return ST_FULL;
    for (int k = poly_cnt[t]; k > i; k--) begin
      poly_coef[t][k]  = poly_coef[t][k-1];
      poly_expon[t][k] = poly_expon[t][k-1];
    end
    poly_coef[t][i]  = c;
    poly_expon[t][i] = ex[ExponW-1:0];
    poly_cnt[t]++;
    return ST_OK;
  endfunction

  function automatic logic [StatW-1:0] multiply_tables();
    logic [StatW-1:0] st;
    int unsigned      s;
    st = ST_OK;
    poly_cnt[TAB_P] = 0;
    for (int i = 0; i < poly_cnt[TAB_A] && st == ST_OK; i++)
      for (int j = 0; j < poly_cnt[TAB_B] && st == ST_OK; j++) begin
        s = poly_expon[TAB_A][i] + poly_expon[TAB_B][j];
        if (s > 65535) st = ST_EOVF;
        else st = merge_term(TAB_P, fixed_mul(poly_coef[TAB_A][i], poly_coef[TAB_B][j]), s);
      end
    if (st == ST_OK) begin
      poly_coef[TAB_A]  = poly_coef[TAB_P];
      poly_expon[TAB_A] = poly_expon[TAB_P];
      poly_cnt[TAB_A]   = poly_cnt[TAB_P];
    end
    return st;
  endfunction

  function automatic void push_word(logic signed [CoefW-1:0] c, logic [ExponW-1:0] e,
                                    logic [StatW-1:0] st, logic lst);
    term_word_t w;
    w.coef  = c;
    w.expon = e;
    w.cnt   = poly_cnt[TAB_A][6:0];
    w.st    = st;
    w.lst   = lst;
    expected_words.push_back(w);
  endfunction

  function automatic void predict_word(logic [OpW-1:0] op, logic signed [CoefW-1:0] c,
                                       logic [ExponW-1:0] ex, logic signed [15:0] fac);
    logic [StatW-1:0] st;
    int               idx;
    st = ST_OK;
    case (op)
      OP_ATTACH_A: st = merge_term(TAB_A, c, ex);
      OP_ATTACH_B: st = merge_term(TAB_B, c, ex);
      OP_ADD: begin
        for (int i = 0; i < poly_cnt[TAB_B]; i++)
          if (merge_term(TAB_A, poly_coef[TAB_B][i], poly_expon[TAB_B][i]) != ST_OK)
            st = ST_FULL;
      end
      OP_SCALE: begin
        for (int i = 0; i < poly_cnt[TAB_A]; i++)
          poly_coef[TAB_A][i] = clamp32(longint'(poly_coef[TAB_A][i]) * longint'(fac));
      end
      OP_REMOVE: begin
        idx = 0;
        while (idx < poly_cnt[TAB_A] && poly_expon[TAB_A][idx] != ex) idx++;
        if (idx == poly_cnt[TAB_A]) st = ST_NF;
        else begin
          for (int i = idx; i + 1 < poly_cnt[TAB_A]; i++) begin
            poly_coef[TAB_A][i]  = poly_coef[TAB_A][i+1];
            poly_expon[TAB_A][i] = poly_expon[TAB_A][i+1];
          end
          poly_cnt[TAB_A]--;
        end
      end
      OP_MULT:    st = multiply_tables();
      OP_CLEAR_A: poly_cnt[TAB_A] = 0;
      OP_CLEAR_B: poly_cnt[TAB_B] = 0;
      OP_LEAD, OP_READ: begin
        if (poly_cnt[TAB_A] == 0) push_word('0, '0, ST_EMPTY, 1'b1);
        else if (op == OP_LEAD) push_word(poly_coef[TAB_A][0], poly_expon[TAB_A][0], ST_OK, 1'b1);
        else
          for (int i = 0; i < poly_cnt[TAB_A]; i++)
            push_word(poly_coef[TAB_A][i], poly_expon[TAB_A][i], ST_OK,
                      i + 1 == poly_cnt[TAB_A]);
        return;
      end
      default: ;
    endcase
    push_word('0, '0, st, 1'b1);
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    term_word_t w;
    if (!rst) begin
      // outputs first: a word out never belongs to the word taken this edge
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) report("unexpected word", out_coef, 0);
        else begin
          w = expected_words.pop_front();
          if (out_coef !== w.coef) report("out_coef", out_coef, w.coef);
          if (out_expon !== w.expon) report("out_expon", out_expon, w.expon);
          if (term_count !== w.cnt) report("term_count", term_count, w.cnt);
          if (status !== w.st) report("status", status, w.st);
          if (last !== w.lst) report("last", last, w.lst);
        end
      end
      if (in_valid && in_ready) predict_word(operation, term_coef, term_expon, scale_factor);
    end
    pending <= expected_words.size();
  end
endmodule

// ===== tb/sparse_polynomial_term_table_top_tb.sv =====
// Testbench top for the sparse polynomial term table: clock, reset, stimulus,
// output backpressure and verdict. Uses sptt_pkg, sptt_checker and the block.
`timescale 1ns / 1ps
module sparse_polynomial_term_table_top_tb;
  import sptt_pkg::*;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [OpW-1:0]          operation = OP_CLEAR_A;
  logic signed [CoefW-1:0] term_coef = '0;
  logic [ExponW-1:0]       term_expon = '0;
  logic signed [15:0]      scale_factor = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [CoefW-1:0] out_coef;
  logic [ExponW-1:0]       out_expon;
  logic [6:0]              term_count;
  logic [StatW-1:0]        status;
  logic                    last;
  int                      fail_count;
  int                      pending;

  // idle odds in percent, per side; changed by the stimulus as phases go by
  int src_idle = 34;
  int snk_idle = 56;
  int words_sent = 0;
  // one long receiver hold-off so the output fills and in_ready drops
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;

  always #6 clk = ~clk;

  sparse_polynomial_term_table_top DUT (
    .clk, .rst, .in_valid, .in_ready, .operation, .term_coef, .term_expon,
    .scale_factor, .out_valid, .out_ready, .out_coef, .out_expon, .term_count,
    .status, .last
  );

  sptt_checker u_checker (
    .clk, .rst, .in_valid, .in_ready, .operation, .term_coef, .term_expon,
    .scale_factor, .out_valid, .out_ready, .out_coef, .out_expon, .term_count,
    .status, .last, .fail_count, .pending
  );

  // receiver: random stalls, or the one long hold
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_ready <= 1'b0;
      hold_left <= 400;
      hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= snk_idle);
    end
  end

  // drive one word, idling at random first, then wait for acceptance
  task automatic send_word(logic [OpW-1:0] op, logic signed [CoefW-1:0] c,
                           logic [ExponW-1:0] ex, logic signed [15:0] fac);
    @(negedge clk);
    while ($urandom_range(99) < src_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    operation    <= op;
    term_coef    <= c;
    term_expon   <= ex;
    scale_factor <= fac;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    // phase changes: swap idle odds, then run flat out with one long hold
    if (words_sent == 50) begin
      src_idle = 56;
      snk_idle = 34;
    end else if (words_sent == 100) begin
      src_idle = 0;
      snk_idle = 0;
      hold_req = 1'b1;
    end
  endtask

  // mostly small exponents so merges and removes hit; sometimes any value
  function automatic logic [ExponW-1:0] pick_expon();
    if ($urandom_range(7) == 0) return ExponW'($urandom);
    return ExponW'($urandom_range(15));
  endfunction

  task automatic directed_words();
    // empty table cases
    send_word(OP_READ, 0, 0, 0);
    send_word(OP_LEAD, 0, 0, 0);
    send_word(OP_REMOVE, 0, 16'd3, 0);
    send_word(OP_MULT, 0, 0, 0);
    // field extremes, saturating merge, merge to zero
    send_word(OP_ATTACH_A, 32'sh7FFF_FFFF, 16'hFFFF, 0);
    send_word(OP_ATTACH_A, 32'sh8000_0000, 16'h0000, 0);
    send_word(OP_ATTACH_A, 32'sh7FFF_FFFF, 16'hFFFF, 0);
    send_word(OP_ATTACH_A, 32'sd1, 16'd5, 0);
    send_word(OP_ATTACH_A, -32'sd1, 16'd5, 0);
    send_word(OP_LEAD, 0, 0, 0);
    send_word(OP_REMOVE, 0, 16'd77, 0);
    send_word(OP_SCALE, 0, 0, 16'sh8000);
    send_word(OP_SCALE, 0, 0, 16'sh7FFF);
    send_word(OP_READ, 0, 0, 0);
    send_word(OP_REMOVE, 0, 16'd5, 0);
    // exponent sum past 16 bits aborts the product
    send_word(OP_ATTACH_B, 32'sh0001_0000, 16'd1, 0);
    send_word(OP_MULT, 0, 0, 0);
    send_word(OP_ADD, 0, 0, 0);
    send_word(OP_CLEAR_A, 0, 0, 0);
    send_word(OP_CLEAR_B, 0, 0, 0);
    // 8 x 8 distinct sums fills A exactly
    for (int i = 0; i < 8; i++) begin
      send_word(OP_ATTACH_A, $urandom, i[15:0], 0);
      send_word(OP_ATTACH_B, $urandom, 16'(8 * i), 0);
    end
    send_word(OP_MULT, 0, 0, 0);
    send_word(OP_READ, 0, 0, 0);
    send_word(OP_ATTACH_A, 32'sd9, 16'd1000, 0);   // full: dropped
    send_word(OP_ATTACH_A, 32'sd9, 16'd3, 0);      // full but merges
    send_word(OP_MULT, 0, 0, 0);                   // too many exponents
    send_word(OP_ATTACH_B, 32'sd4, 16'd9000, 0);
    send_word(OP_ADD, 0, 0, 0);                    // one B term does not fit
    send_word(4'd15, $urandom, 16'hFFFF, 16'hFFFF); // unknown codes
    send_word(4'd10, 0, 0, 0);
    send_word(OP_CLEAR_A, 0, 0, 0);
    send_word(OP_CLEAR_B, 0, 0, 0);
  endtask

  task automatic random_words();
    int start;
    int n;
    logic [OpW-1:0] op;
    start = words_sent;
    while (words_sent - start < 100) begin
      if ($urandom_range(9) < 6) begin
        // well-formed: fresh small tables, then a few operations on them
        send_word(OP_CLEAR_A, 0, 0, 0);
        send_word(OP_CLEAR_B, 0, 0, 0);
        n = $urandom_range(6, 1);
        for (int i = 0; i < n; i++) send_word(OP_ATTACH_A, $urandom, pick_expon(), 0);
        n = $urandom_range(6, 1);
        for (int i = 0; i < n; i++) send_word(OP_ATTACH_B, $urandom, pick_expon(), 0);
        n = $urandom_range(3, 1);
        for (int i = 0; i < n; i++) begin
          case ($urandom_range(6))
            0: op = OP_MULT;
            1: op = OP_ADD;
            2: op = OP_SCALE;
            3: op = OP_REMOVE;
            4: op = OP_LEAD;
            5: op = OP_ATTACH_A;
            default: op = OP_READ;
          endcase
          send_word(op, $urandom, pick_expon(), 16'($urandom));
        end
        send_word(OP_READ, 0, 0, 0);
      end else begin
        // noise; multiply left out so table sizes stay bounded
        op = OpW'($urandom_range(15));
        if (op == OP_MULT) op = OP_READ;
        send_word(op, $urandom, pick_expon(), 16'($urandom));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    directed_words();
    random_words();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #36_000_000;
    $display("Verification failed");
    $finish;
  end
endmodule

// ===== files.f =====
rtl/sptt_pkg.sv
rtl/sptt_mem.sv
rtl/sparse_polynomial_term_table_top.sv
tb/sptt_checker.sv
tb/sparse_polynomial_term_table_top_tb.sv
